// ----- rtl/smpq_pkg.sv -----
`default_nettype none

package smpq_pkg;

  localparam int DATA_W       = 32;
  localparam int PRIO_W       = 16;
  localparam int ENTRY_W      = DATA_W + PRIO_W;
  localparam int CAPACITY_DEF = 16;

  // operation codes carried in s_tuser
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    load;        // latch the accepted item
    logic    deq_read;    // read the head entry
    logic    deq_done;    // pop the head entry
    logic    scan_start;  // open a hole at the tail, read the entry before it
    logic    shift;       // move the read entry into the hole
    logic    insert;      // write the new entry into the hole
    logic    res_load;    // capture a result
    status_t res_code;
    logic    out_load;    // move the captured result to the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_deq;
    logic empty;
    logic full;
    logic greater;   // entry just read ranks after the new one
    logic rem_one;   // only one entry is left to compare
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/stable_min_priority_queue_core.sv -----
// empty and full results are captured in S_DECIDE, a dequeue result in S_DEQ_WAIT;
// an enqueue moves each stored entry ranking after the new one up a place in S_SCAN
// (one ram read/write per entry), then inserts the new entry; the queue takes
// one item at a time, and the next input transfer is taken the cycle after the result
// has entered the output register; a result still waiting there does not block it
// reset: rst (synchronous, active high) empties the queue and drops any pending result
`default_nettype none

module stable_min_priority_queue_core #(
  parameter int CAPACITY = smpq_pkg::CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [31:0] data_value, [47:32] priority_req
  input  wire logic [0:0]  s_tuser,   // [0] func
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // [31:0] out_data, [47:32] out_priority
  output logic      [1:0]  m_tuser    // [1:0] status
);

  smpq_pkg::cmd_t    cmd;
  smpq_pkg::stat_t   stat;
  smpq_pkg::status_t out_status;
  logic [smpq_pkg::DATA_W-1:0] out_data;
  logic [smpq_pkg::PRIO_W-1:0] out_prio;

  // sequencer: walks each item through decide, ram scan and result handoff
  smpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // sorted circular store in ram, item and result registers
  smpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_func    (s_tuser[0]),
    .in_data    (s_tdata[31:0]),
    .in_prio    (s_tdata[47:32]),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .out_status (out_status),
    .out_data   (out_data),
    .out_prio   (out_prio),
    .cmd        (cmd),
    .stat       (stat)
  );

  // pack result fields, data in the low bits
  assign m_tdata = {out_prio, out_data};
  assign m_tuser = out_status;

endmodule

`default_nettype wire

// ----- rtl/smpq_ram.sv -----
`default_nettype none

module smpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/smpq_ctrl.sv -----
`default_nettype none

module smpq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire smpq_pkg::stat_t stat,
  output smpq_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DEQ_WAIT,
    S_SCAN,
    S_INSERT,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.res_code = smpq_pkg::ST_ENQUEUED;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.item_deq) begin
          if (stat.empty) begin
            cmd.res_load = 1'b1;
            cmd.res_code = smpq_pkg::ST_EMPTY;
            state_next   = S_FINISH;
          end else begin
            cmd.deq_read = 1'b1;
            state_next   = S_DEQ_WAIT;
          end
        end else if (stat.full) begin
          cmd.res_load = 1'b1;
          cmd.res_code = smpq_pkg::ST_FULL;
          state_next   = S_FINISH;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = stat.empty ? S_INSERT : S_SCAN;
        end
      end
      S_DEQ_WAIT: begin
        cmd.deq_done = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_code = smpq_pkg::ST_DEQUEUED;
        state_next   = S_FINISH;
      end
      S_SCAN: begin
        if (stat.greater) begin
          cmd.shift  = 1'b1;
          state_next = stat.rem_one ? S_INSERT : S_SCAN;
        end else begin
          cmd.insert   = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_code = smpq_pkg::ST_ENQUEUED;
          state_next   = S_FINISH;
        end
      end
      S_INSERT: begin
        cmd.insert   = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_code = smpq_pkg::ST_ENQUEUED;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/smpq_datapath.sv -----
`default_nettype none

module smpq_datapath #(
  parameter int CAPACITY = smpq_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_func,
  input  wire logic [smpq_pkg::DATA_W-1:0]   in_data,
  input  wire logic [smpq_pkg::PRIO_W-1:0]   in_prio,
  input  wire logic                          m_tready,
  output logic                               m_tvalid,
  output smpq_pkg::status_t                  out_status,
  output logic      [smpq_pkg::DATA_W-1:0]   out_data,
  output logic      [smpq_pkg::PRIO_W-1:0]   out_prio,
  input  wire smpq_pkg::cmd_t                cmd,
  output smpq_pkg::stat_t                    stat
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = smpq_pkg::ENTRY_W;
  localparam int DW = smpq_pkg::DATA_W;
  localparam int PW = smpq_pkg::PRIO_W;

  // circular sorted store: head holds the lowest priority
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [AW-1:0] pos;     // physical index of the hole
  logic [CW-1:0] rem;     // entries still to compare

  logic          item_func;
  logic [DW-1:0] item_data;
  logic [PW-1:0] item_prio;

  smpq_pkg::status_t res_code;
  logic [DW-1:0]     res_data;
  logic [PW-1:0]     res_prio;

  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] tail_m1;
  logic [AW-1:0] pos_m1;
  logic [AW-1:0] pos_m2;
  logic [AW-1:0] head_p1;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] x);
    return (x == '0) ? AW'(CAPACITY - 1) : x - 1'b1;
  endfunction

  function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] x);
    return (x == AW'(CAPACITY - 1)) ? '0 : x + 1'b1;
  endfunction

  assign tail_sum = (CW + 1)'(head) + (CW + 1)'(count);
  assign tail     = (tail_sum >= (CW + 1)'(CAPACITY))
                  ? AW'(tail_sum - (CW + 1)'(CAPACITY)) : tail_sum[AW-1:0];
  assign tail_m1  = dec_wrap(tail);
  assign pos_m1   = dec_wrap(pos);
  assign pos_m2   = dec_wrap(pos_m1);
  assign head_p1  = inc_wrap(head);

  always_comb begin
    ram_raddr = head;
    if (cmd.scan_start) begin
      ram_raddr = tail_m1;
    end else if (cmd.shift) begin
      ram_raddr = pos_m2;
    end
  end

  assign ram_we    = cmd.shift | cmd.insert;
  assign ram_waddr = pos;
  assign ram_wdata = cmd.shift ? ram_rdata : {item_prio, item_data};

  smpq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign stat.item_deq = (item_func == smpq_pkg::FUNC_DEQ);
  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CW'(CAPACITY));
  assign stat.greater  = $signed(ram_rdata[EW-1:DW]) > $signed(item_prio);
  assign stat.rem_one  = (rem == CW'(1));
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_func <= in_func;
      item_data <= in_data;
      item_prio <= in_prio;
    end
    if (cmd.scan_start) begin
      pos <= tail;
      rem <= count;
    end else if (cmd.shift) begin
      pos <= pos_m1;
      rem <= rem - 1'b1;
    end
    if (cmd.res_load) begin
      res_code <= cmd.res_code;
      if (cmd.res_code == smpq_pkg::ST_DEQUEUED) begin
        res_data <= ram_rdata[DW-1:0];
        res_prio <= ram_rdata[EW-1:DW];
      end else begin
        res_data <= '0;
        res_prio <= '0;
      end
    end
    if (cmd.out_load) begin
      out_status <= res_code;
      out_data   <= res_data;
      out_prio   <= res_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.deq_done) begin
        head  <= head_p1;
        count <= count - 1'b1;
      end else if (cmd.insert) begin
        count <= count + 1'b1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
